// ----- design/char_stream_tokenizer_assert.svh -----
// Assertion macros for the character stream tokenizer.
// Used by the top level; no other dependencies.
`ifndef CHAR_STREAM_TOKENIZER_ASSERT_SVH
`define CHAR_STREAM_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define CST_ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("cst assertion failed: never");
`define CST_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("cst assertion failed: implication");
`else
`define CST_ASSERT_NEVER(lbl, clk, rstn, expr)
`define CST_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- design/cst_pkg.sv -----
// Shared types, codes and character classes for the character stream tokenizer.
// No dependencies.
`timescale 1ns / 1ps

package cst_pkg;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_input;
	} src_item_t;

	typedef enum logic [4:0] {
		K_ID      = 5'd0,
		K_NUM     = 5'd1,
		K_ASSIGN  = 5'd2,
		K_DCOLON  = 5'd3,
		K_DOT     = 5'd4,
		K_COMMA   = 5'd5,
		K_LPAREN  = 5'd6,
		K_RPAREN  = 5'd7,
		K_EQ      = 5'd8,
		K_GT      = 5'd9,
		K_LT      = 5'd10,
		K_GE      = 5'd11,
		K_LE      = 5'd12,
		K_STRING  = 5'd13,
		K_COMMENT = 5'd14,
		K_UNKNOWN = 5'd15,
		K_UNTERM  = 5'd16
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [31:0] start_offset;
		logic [15:0] length;
		logic [31:0] number_value;
		logic        last;
	} tok_item_t;

	typedef struct packed {
		logic [1:0] cnt;
		tok_item_t  r0;
		tok_item_t  r1;
	} push_t;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = 2;
	localparam int unsigned QCNT_W = 3;

	typedef struct packed {
		logic [QCNT_W-1:0] fill;
		logic              room;
	} rbuf_stat_t;

	typedef enum logic [10:0] {
		ST_START    = 11'b000_0000_0001,
		ST_ID       = 11'b000_0000_0010,
		ST_NUM      = 11'b000_0000_0100,
		ST_EQ       = 11'b000_0000_1000,
		ST_GT       = 11'b000_0001_0000,
		ST_LT       = 11'b000_0010_0000,
		ST_COLON    = 11'b000_0100_0000,
		ST_SLASH    = 11'b000_1000_0000,
		ST_STR      = 11'b001_0000_0000,
		ST_CMT      = 11'b010_0000_0000,
		ST_CMT_STAR = 11'b100_0000_0000
	} scan_state_t;

	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	function automatic logic is_letter(logic [7:0] c);
		return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c inside {8'h20, [8'h09:8'h0d]};
	endfunction

endpackage

// ----- design/cst_scan.sv -----
// Input reg and scanner automaton: 1 char/cycle with queue room, up to two token records.
// Depends on cst_pkg.
`timescale 1ns / 1ps

module cst_scan #(
	parameter int unsigned VALUE_WIDTH  = 32,
	parameter int unsigned OFFSET_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_ready,
	input  cst_pkg::src_item_t src_data,
	input  logic               room,
	output cst_pkg::push_t     push
);

	localparam int unsigned AW = VALUE_WIDTH + 4;
	localparam int unsigned LW = OFFSET_WIDTH + 1;

	logic                     v_s1;
	cst_pkg::src_item_t       item_s1;
	cst_pkg::scan_state_t     state_q, state_d;
	logic [OFFSET_WIDTH-1:0]  off_q, off_d;
	logic [OFFSET_WIDTH-1:0]  start_q, start_d;
	logic [VALUE_WIDTH-1:0]   acc_q, acc_d;

	logic                     take;
	logic [7:0]               c;
	logic [OFFSET_WIDTH-1:0]  span;
	logic [LW-1:0]            span_p1;
	logic [15:0]              len_sat, len_p1_sat;
	logic [AW-1:0]            acc_wide;
	logic [VALUE_WIDTH-1:0]   acc_step;
	logic [31:0]              so_tok, so_cur, val32;
	logic                     again, have_first, have_second;
	cst_pkg::tok_item_t       first, second;

	function automatic cst_pkg::tok_item_t mk(cst_pkg::tok_kind_t k, logic [31:0] so,
			logic [15:0] len, logic [31:0] v);
		cst_pkg::tok_item_t r;
		r.kind         = k;
		r.start_offset = so;
		r.length       = len;
		r.number_value = v;
		r.last         = 1'b0;
		return r;
	endfunction

	assign take      = v_s1 & room;
	assign src_ready = ~v_s1 | room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (src_ready) begin
			v_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready) begin
			item_s1 <= src_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cst_pkg::ST_START;
			off_q   <= '0;
			start_q <= '0;
			acc_q   <= '0;
		end else if (take) begin
			state_q <= state_d;
			off_q   <= off_d;
			start_q <= start_d;
			acc_q   <= acc_d;
		end
	end

	assign c          = item_s1.ch;
	assign span       = off_q - start_q;
	assign span_p1    = {1'b0, span} + LW'(1);
	assign len_sat    = (|(span >> 16)) ? 16'hFFFF : 16'(span);
	assign len_p1_sat = (|(span_p1 >> 16)) ? 16'hFFFF : 16'(span_p1);
	assign acc_wide   = (AW'(acc_q) << 3) + (AW'(acc_q) << 1) + AW'(c - cst_pkg::CH_ZERO);
	assign acc_step   = (|acc_wide[AW-1:VALUE_WIDTH]) ? '1 : acc_wide[VALUE_WIDTH-1:0];
	assign so_tok     = 32'(start_q);
	assign so_cur     = 32'(off_q);
	assign val32      = 32'(acc_q);

	always_comb begin
		state_d     = state_q;
		off_d       = off_q + OFFSET_WIDTH'(1);
		start_d     = start_q;
		acc_d       = acc_q;
		again       = 1'b0;
		have_first  = 1'b0;
		have_second = 1'b0;
		first       = '0;
		second      = '0;
		if (item_s1.end_of_input) begin
			have_first = 1'b1;
			case (state_q)
				cst_pkg::ST_ID:    first = mk(cst_pkg::K_ID, so_tok, len_sat, 32'd0);
				cst_pkg::ST_NUM:   first = mk(cst_pkg::K_NUM, so_tok, len_sat, val32);
				cst_pkg::ST_EQ:    first = mk(cst_pkg::K_ASSIGN, so_tok, 16'd1, 32'd0);
				cst_pkg::ST_GT:    first = mk(cst_pkg::K_GT, so_tok, 16'd1, 32'd0);
				cst_pkg::ST_LT:    first = mk(cst_pkg::K_LT, so_tok, 16'd1, 32'd0);
				cst_pkg::ST_COLON,
				cst_pkg::ST_SLASH: first = mk(cst_pkg::K_UNKNOWN, so_tok, 16'd1, 32'd0);
				cst_pkg::ST_STR,
				cst_pkg::ST_CMT,
				cst_pkg::ST_CMT_STAR: first = mk(cst_pkg::K_UNTERM, so_tok, len_sat, 32'd0);
				default:           have_first = 1'b0;
			endcase
			state_d = cst_pkg::ST_START;
			off_d   = '0;
			start_d = '0;
			acc_d   = '0;
		end else begin
			case (state_q)
				cst_pkg::ST_ID: begin
					if (!(cst_pkg::is_letter(c) || cst_pkg::is_digit(c))) begin
						have_first = 1'b1;
						first      = mk(cst_pkg::K_ID, so_tok, len_sat, 32'd0);
						again      = 1'b1;
					end
				end
				cst_pkg::ST_NUM: begin
					if (cst_pkg::is_digit(c)) begin
						acc_d = acc_step;
					end else begin
						have_first = 1'b1;
						first      = mk(cst_pkg::K_NUM, so_tok, len_sat, val32);
						again      = 1'b1;
					end
				end
				cst_pkg::ST_EQ: begin
					have_first = 1'b1;
					if (c == cst_pkg::CH_EQ) begin
						first = mk(cst_pkg::K_EQ, so_tok, 16'd2, 32'd0);
					end else begin
						first = mk(cst_pkg::K_ASSIGN, so_tok, 16'd1, 32'd0);
						again = 1'b1;
					end
					state_d = cst_pkg::ST_START;
				end
				cst_pkg::ST_GT: begin
					have_first = 1'b1;
					if (c == cst_pkg::CH_EQ) begin
						first = mk(cst_pkg::K_GE, so_tok, 16'd2, 32'd0);
					end else begin
						first = mk(cst_pkg::K_GT, so_tok, 16'd1, 32'd0);
						again = 1'b1;
					end
					state_d = cst_pkg::ST_START;
				end
				cst_pkg::ST_LT: begin
					have_first = 1'b1;
					if (c == cst_pkg::CH_EQ) begin
						first = mk(cst_pkg::K_LE, so_tok, 16'd2, 32'd0);
					end else begin
						first = mk(cst_pkg::K_LT, so_tok, 16'd1, 32'd0);
						again = 1'b1;
					end
					state_d = cst_pkg::ST_START;
				end
				cst_pkg::ST_COLON: begin
					have_first = 1'b1;
					if (c == cst_pkg::CH_COLON) begin
						first = mk(cst_pkg::K_DCOLON, so_tok, 16'd2, 32'd0);
					end else begin
						first = mk(cst_pkg::K_UNKNOWN, so_tok, 16'd1, 32'd0);
						again = 1'b1;
					end
					state_d = cst_pkg::ST_START;
				end
				cst_pkg::ST_SLASH: begin
					if (c == cst_pkg::CH_STAR) begin
						state_d = cst_pkg::ST_CMT;
					end else begin
						have_first = 1'b1;
						first      = mk(cst_pkg::K_UNKNOWN, so_tok, 16'd1, 32'd0);
						again      = 1'b1;
					end
				end
				cst_pkg::ST_STR: begin
					if (c == cst_pkg::CH_QUOTE) begin
						have_first = 1'b1;
						first      = mk(cst_pkg::K_STRING, so_tok, len_p1_sat, 32'd0);
						state_d    = cst_pkg::ST_START;
					end
				end
				cst_pkg::ST_CMT: begin
					if (c == cst_pkg::CH_STAR) begin
						state_d = cst_pkg::ST_CMT_STAR;
					end
				end
				cst_pkg::ST_CMT_STAR: begin
					if (c == cst_pkg::CH_SLASH) begin
						have_first = 1'b1;
						first      = mk(cst_pkg::K_COMMENT, so_tok, len_p1_sat, 32'd0);
						state_d    = cst_pkg::ST_START;
					end else if (c != cst_pkg::CH_STAR) begin
						state_d = cst_pkg::ST_CMT;
					end
				end
				default: again = 1'b1;
			endcase
			// rescan the current character from the start state
			if (again) begin
				start_d = off_q;
				state_d = cst_pkg::ST_START;
				second  = mk(cst_pkg::K_UNKNOWN, so_cur, 16'd1, 32'd0);
				if (cst_pkg::is_letter(c)) begin
					state_d = cst_pkg::ST_ID;
				end else if (cst_pkg::is_digit(c)) begin
					state_d = cst_pkg::ST_NUM;
					acc_d   = VALUE_WIDTH'(c - cst_pkg::CH_ZERO);
				end else begin
					case (c)
						cst_pkg::CH_EQ:     state_d = cst_pkg::ST_EQ;
						cst_pkg::CH_GT:     state_d = cst_pkg::ST_GT;
						cst_pkg::CH_LT:     state_d = cst_pkg::ST_LT;
						cst_pkg::CH_COLON:  state_d = cst_pkg::ST_COLON;
						cst_pkg::CH_SLASH:  state_d = cst_pkg::ST_SLASH;
						cst_pkg::CH_QUOTE:  state_d = cst_pkg::ST_STR;
						cst_pkg::CH_DOT: begin
							have_second = 1'b1;
							second.kind = cst_pkg::K_DOT;
						end
						cst_pkg::CH_COMMA: begin
							have_second = 1'b1;
							second.kind = cst_pkg::K_COMMA;
						end
						cst_pkg::CH_LPAREN: begin
							have_second = 1'b1;
							second.kind = cst_pkg::K_LPAREN;
						end
						cst_pkg::CH_RPAREN: begin
							have_second = 1'b1;
							second.kind = cst_pkg::K_RPAREN;
						end
						default:            have_second = ~cst_pkg::is_space(c);
					endcase
				end
			end
		end
	end

	always_comb begin
		push    = '0;
		push.r1 = second;
		push.r0 = have_first ? first : second;
		if (have_first && have_second) begin
			push.r1.last = 1'b1;
		end else begin
			push.r0.last = 1'b1;
		end
		if (take) begin
			push.cnt = {1'b0, have_first} + {1'b0, have_second};
		end
	end

endmodule

// ----- design/cst_rbuf.sv -----
// Four-entry result queue: takes up to two token records a cycle, hands out one.
// Depends on cst_pkg.
`timescale 1ns / 1ps

module cst_rbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  cst_pkg::push_t      push,
	output cst_pkg::rbuf_stat_t stat,
	output logic                tok_valid,
	input  logic                tok_ready,
	output cst_pkg::tok_item_t  tok_data
);

	cst_pkg::tok_item_t             mem_q [cst_pkg::QDEPTH];
	logic [cst_pkg::QPTR_W-1:0]     wp_q, rp_q, wp_nx1;
	logic [cst_pkg::QCNT_W-1:0]     fill_q;
	logic                           pop;

	assign wp_nx1    = wp_q + cst_pkg::QPTR_W'(1);
	assign tok_valid = fill_q != '0;
	assign tok_data  = mem_q[rp_q];
	assign pop       = tok_valid & tok_ready;
	assign stat.fill = fill_q;
	assign stat.room = fill_q <= cst_pkg::QCNT_W'(cst_pkg::QDEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wp_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wp_nx1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else begin
			wp_q   <= wp_q + cst_pkg::QPTR_W'(push.cnt);
			rp_q   <= rp_q + cst_pkg::QPTR_W'(pop);
			fill_q <= fill_q + cst_pkg::QCNT_W'(push.cnt) - cst_pkg::QCNT_W'(pop);
		end
	end

endmodule

// ----- design/char_stream_tokenizer.sv -----
// Character stream tokenizer top level: input register, scanner, result queue.
// Depends on cst_pkg, cst_scan, cst_rbuf and char_stream_tokenizer_assert.svh.
//
// Usage:
// - src channel carries one character (or an end-of-input flag) per transfer;
//   tok channel carries one token record per transfer, last marks the final
//   record caused by one character.
// - A character is taken into the input register at its transfer; the
//   scanner reads it there and, once the queue has room, writes its records
//   into the four-entry result queue, from which they transfer on tok.
// - Throughput: one character per cycle while the queue holds two or fewer
//   records; the queue drains one record per cycle while tok_ready is high,
//   so characters that close one token and are a one-character token
//   themselves (two records) are paced by the tok side.
// - A stall on tok fills the queue; src_ready drops while a character waits in
//   the input register and the queue could not take two more records, and the
//   scanner holds its state.
// - Reset empties the queue and the input register and puts the scanner in
//   its start state with offset, token start and accumulator at zero.
// - End of input flushes the pending token and returns the scanner to the
//   same state as after reset.
`timescale 1ns / 1ps
`include "char_stream_tokenizer_assert.svh"

module char_stream_tokenizer #(
	parameter int unsigned VALUE_WIDTH  = 32,
	parameter int unsigned OFFSET_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_ready,
	input  cst_pkg::src_item_t src_data,
	output logic               tok_valid,
	input  logic               tok_ready,
	output cst_pkg::tok_item_t tok_data
);

	cst_pkg::push_t      push;
	cst_pkg::rbuf_stat_t stat;

	cst_scan #(
		.VALUE_WIDTH  (VALUE_WIDTH),
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.room      (stat.room),
		.push      (push)
	);

	cst_rbuf u_rbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.stat      (stat),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_data  (tok_data)
	);

	`CST_ASSERT_NEVER(a_no_overflow, clk, arst_n, stat.fill > cst_pkg::QCNT_W'(cst_pkg::QDEPTH))
	`CST_ASSERT_IMPLY(a_push_has_room, clk, arst_n, push.cnt != 2'd0, stat.room)
	`CST_ASSERT_IMPLY(a_last_on_pair, clk, arst_n, push.cnt == 2'd2, !push.r0.last && push.r1.last)
	`CST_ASSERT_IMPLY(a_last_on_single, clk, arst_n, push.cnt == 2'd1, push.r0.last)

endmodule
